@@ design/oetr_pkg.sv @@
// oetr_pkg: shared types and constants for the overwriting event trace ring
// field widths, opcodes, register indexes, pipeline side-band and
// reciprocal constants used by the time stamp split; no dependencies
package oetr_pkg;

  localparam int LEVEL_W   = 2;
  localparam int TAG_W     = 3;
  localparam int TIME_W    = 32;
  localparam int OPCODE_W  = 2;
  localparam int HOURS_W   = 11;
  localparam int MINUTES_W = 6;
  localparam int SECONDS_W = 6;
  localparam int MILLIS_W  = 10;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;

  localparam logic [OPCODE_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_POP  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_HIST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_REMOTE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SERIAL_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEB_LIMIT    = 2'd2;

  // t / 1000 == (t * DIV1000_MUL) >> DIV1000_SH for every 32-bit t
  localparam int DIV1000_MUL_W = 29;
  localparam logic [DIV1000_MUL_W-1:0] DIV1000_MUL = 29'd274877907;
  localparam int DIV1000_SH = 38;
  // n / 60 == (n * DIV60_MUL) >> DIV60_SH for every n below 2**23
  localparam int DIV60_MUL_W = 24;
  localparam logic [DIV60_MUL_W-1:0] DIV60_MUL = 24'd8947849;
  localparam int DIV60_SH = 29;

  localparam int MS_PER_S  = 1000;
  localparam int S_PER_MIN = 60;
  localparam int MIN_PER_H = 60;

  // whole seconds fit 23 bits, whole minutes 17 bits
  localparam int Q1_W = 23;
  localparam int Q2_W = 17;

  typedef struct packed {
    logic [LEVEL_W-1:0] remote;
    logic [LEVEL_W-1:0] serial;
    logic [LEVEL_W-1:0] web;
  } lim_t;

  // side-band that travels with each read issued into the result pipeline
  typedef struct packed {
    logic invalid;
    logic hist;
    logic last;
    logic net;
  } meta_t;

endpackage

@@ design/oetr_in_if.sv @@
// oetr_in_if: input channel, valid/ready with one trace command
// depends on oetr_pkg for field widths
interface oetr_in_if #(
  parameter int MSG_W = 16
);
  logic                           valid;
  logic                           ready;
  logic [oetr_pkg::OPCODE_W-1:0]  opcode;
  logic [oetr_pkg::LEVEL_W-1:0]   level;
  logic [oetr_pkg::TAG_W-1:0]     tag;
  logic [oetr_pkg::TIME_W-1:0]    time_ms;
  logic [MSG_W-1:0]               message_ref;
  logic                           network_up;

  modport source (output valid, opcode, level, tag, time_ms, message_ref, network_up,
                  input ready);
  modport sink   (input valid, opcode, level, tag, time_ms, message_ref, network_up,
                  output ready);
endinterface

@@ design/oetr_out_if.sv @@
// oetr_out_if: result channel, valid/ready with one emitted record
// depends on oetr_pkg for field widths
interface oetr_out_if #(
  parameter int MSG_W = 16
);
  logic                            valid;
  logic                            ready;
  logic                            valid_res;
  logic                            last;
  logic [oetr_pkg::LEVEL_W-1:0]    rec_level;
  logic [oetr_pkg::TAG_W-1:0]      rec_tag;
  logic [oetr_pkg::HOURS_W-1:0]    stamp_hours;
  logic [oetr_pkg::MINUTES_W-1:0]  stamp_minutes;
  logic [oetr_pkg::SECONDS_W-1:0]  stamp_seconds;
  logic [oetr_pkg::MILLIS_W-1:0]   stamp_millis;
  logic [MSG_W-1:0]                rec_message;
  logic                            to_remote;
  logic                            to_serial;
  logic                            to_web;

  modport source (output valid, valid_res, last, rec_level, rec_tag, stamp_hours,
                  stamp_minutes, stamp_seconds, stamp_millis, rec_message,
                  to_remote, to_serial, to_web,
                  input ready);
  modport sink   (input valid, valid_res, last, rec_level, rec_tag, stamp_hours,
                  stamp_minutes, stamp_seconds, stamp_millis, rec_message,
                  to_remote, to_serial, to_web,
                  output ready);
endinterface

@@ design/oetr_cfg_if.sv @@
// oetr_cfg_if: register write channel, valid/ready with index and data
// depends on oetr_pkg for field widths
interface oetr_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [oetr_pkg::CFG_IDX_W-1:0]   index;
  logic [oetr_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/oetr_ram.sv @@
// oetr_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module oetr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

@@ design/oetr_ctrl.sv @@
// oetr_ctrl: ring pointers, level limits and the command sequencer
// drives both rams and issues reads into the result pipeline; uses oetr_pkg,
// oetr_in_if and oetr_cfg_if
module oetr_ctrl #(
  parameter int RING_DEPTH = 64,
  parameter int MSG_W      = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  oetr_in_if.sink                       in_ch,
  oetr_cfg_if.sink                      cfg_ch,
  input  logic                          adv,
  input  logic [oetr_pkg::LEVEL_W-1:0]  lvl_rdata,
  output logic                          wr_en,
  output logic [$clog2(RING_DEPTH)-1:0] wr_addr,
  output logic [oetr_pkg::LEVEL_W+oetr_pkg::TAG_W+oetr_pkg::TIME_W+MSG_W-1:0] wr_data,
  output logic                          rec_re,
  output logic [$clog2(RING_DEPTH)-1:0] rec_raddr,
  output logic                          lvl_re,
  output logic [$clog2(RING_DEPTH)-1:0] lvl_raddr,
  output logic                          iss_v,
  output oetr_pkg::meta_t               iss_meta,
  output oetr_pkg::lim_t                lim
);
  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EMIT} state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   wr_idx_r, wr_idx_nxt;
  logic [AW-1:0]   rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]   unsent_r, unsent_nxt;
  logic [CW-1:0]   filled_r, filled_nxt;
  oetr_pkg::lim_t  lim_r, lim_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [AW-1:0]   addr_r, addr_nxt;
  logic            chk_v_r, chk_v_nxt;
  logic [AW-1:0]   chk_i_r, chk_i_nxt;
  logic [AW-1:0]   last_pass_r, last_pass_nxt;
  logic            any_pass_r, any_pass_nxt;

  logic            accept;
  logic            issuing;
  logic [AW-1:0]   start_idx;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] x);
    logic [AW-1:0] y;
    y = (x == AW'(RING_DEPTH - 1)) ? '0 : x + 1'b1;
    return y;
  endfunction

  assign in_ch.ready  = (state_r == ST_IDLE) && adv;
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && in_ch.ready;
  assign issuing      = (state_r == ST_SCAN) && (cnt_r < filled_r);
  // oldest stored slot: slot 0 until the ring has wrapped once
  assign start_idx    = (filled_r < CW'(RING_DEPTH)) ? '0 : wr_idx_r;

  assign wr_addr   = wr_idx_r;
  assign wr_data   = {in_ch.level, in_ch.tag, in_ch.time_ms, in_ch.message_ref};
  assign lvl_re    = issuing;
  assign lvl_raddr = addr_r;
  assign lim       = lim_r;

  always_comb begin
    state_nxt     = state_r;
    wr_idx_nxt    = wr_idx_r;
    rd_idx_nxt    = rd_idx_r;
    unsent_nxt    = unsent_r;
    filled_nxt    = filled_r;
    lim_nxt       = lim_r;
    cnt_nxt       = cnt_r;
    addr_nxt      = addr_r;
    chk_v_nxt     = chk_v_r;
    chk_i_nxt     = chk_i_r;
    last_pass_nxt = last_pass_r;
    any_pass_nxt  = any_pass_r;
    wr_en         = 1'b0;
    rec_re        = 1'b0;
    rec_raddr     = rd_idx_r;
    iss_v         = 1'b0;
    iss_meta      = '0;

    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        oetr_pkg::CFG_REMOTE_LIMIT: lim_nxt.remote = cfg_ch.data;
        oetr_pkg::CFG_SERIAL_LIMIT: lim_nxt.serial = cfg_ch.data;
        oetr_pkg::CFG_WEB_LIMIT:    lim_nxt.web    = cfg_ch.data;
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_ch.opcode)
            oetr_pkg::OP_PUSH: begin
              wr_en      = 1'b1;
              wr_idx_nxt = wrap_inc(wr_idx_r);
              // full ring: the oldest unsent record is lost
              if (unsent_r == CW'(RING_DEPTH)) begin
                rd_idx_nxt = wrap_inc(wr_idx_r);
              end else begin
                unsent_nxt = unsent_r + 1'b1;
              end
              if (filled_r < CW'(RING_DEPTH)) begin
                filled_nxt = filled_r + 1'b1;
              end
            end
            oetr_pkg::OP_POP: begin
              iss_v         = 1'b1;
              iss_meta.last = 1'b1;
              iss_meta.net  = in_ch.network_up;
              if (unsent_r == '0) begin
                iss_meta.invalid = 1'b1;
              end else begin
                rec_re     = 1'b1;
                rd_idx_nxt = wrap_inc(rd_idx_r);
                unsent_nxt = unsent_r - 1'b1;
              end
            end
            oetr_pkg::OP_HIST: begin
              if (filled_r == '0) begin
                iss_v            = 1'b1;
                iss_meta.invalid = 1'b1;
                iss_meta.last    = 1'b1;
              end else begin
                state_nxt    = ST_SCAN;
                cnt_nxt      = '0;
                addr_nxt     = start_idx;
                chk_v_nxt    = 1'b0;
                any_pass_nxt = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        // first pass over the levels finds the last record that passes
        chk_v_nxt = issuing;
        if (issuing) begin
          cnt_nxt   = cnt_r + 1'b1;
          addr_nxt  = wrap_inc(addr_r);
          chk_i_nxt = cnt_r[AW-1:0];
        end
        if (chk_v_r && (lvl_rdata <= lim_r.web)) begin
          last_pass_nxt = chk_i_r;
          any_pass_nxt  = 1'b1;
        end
        if (!issuing && !chk_v_r) begin
          if (any_pass_r) begin
            state_nxt = ST_EMIT;
            cnt_nxt   = '0;
            addr_nxt  = start_idx;
          end else if (adv) begin
            iss_v            = 1'b1;
            iss_meta.invalid = 1'b1;
            iss_meta.last    = 1'b1;
            state_nxt        = ST_IDLE;
          end
        end
      end

      ST_EMIT: begin
        // second pass reads every slot up to the last passing one
        if (adv) begin
          iss_v         = 1'b1;
          rec_re        = 1'b1;
          rec_raddr     = addr_r;
          iss_meta.hist = 1'b1;
          iss_meta.last = (cnt_r[AW-1:0] == last_pass_r);
          cnt_nxt       = cnt_r + 1'b1;
          addr_nxt      = wrap_inc(addr_r);
          if (cnt_r[AW-1:0] == last_pass_r) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      wr_idx_r   <= '0;
      rd_idx_r   <= '0;
      unsent_r   <= '0;
      filled_r   <= '0;
      lim_r      <= '0;
      chk_v_r    <= 1'b0;
      any_pass_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      wr_idx_r   <= wr_idx_nxt;
      rd_idx_r   <= rd_idx_nxt;
      unsent_r   <= unsent_nxt;
      filled_r   <= filled_nxt;
      lim_r      <= lim_nxt;
      chk_v_r    <= chk_v_nxt;
      any_pass_r <= any_pass_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    addr_r      <= addr_nxt;
    chk_i_r     <= chk_i_nxt;
    last_pass_r <= last_pass_nxt;
  end

  a_unsent_le_filled: assert property (@(posedge clk) disable iff (!rst_n)
    unsent_r <= filled_r)
    else $error("unsent count exceeds filled count");

  a_full_ptrs_meet: assert property (@(posedge clk) disable iff (!rst_n)
    (unsent_r == CW'(RING_DEPTH)) |-> (rd_idx_r == wr_idx_r))
    else $error("full ring with read and write pointers apart");

  a_emit_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (any_pass_r && (cnt_r <= CW'(last_pass_r))))
    else $error("history emission ran past the last passing slot");

  a_issue_on_adv: assert property (@(posedge clk) disable iff (!rst_n)
    iss_v |-> (adv && (state_r != ST_SCAN || !chk_v_r)))
    else $error("read issued into a stalled pipeline");
endmodule

@@ design/oetr_split.sv @@
// oetr_split: result pipeline behind the record ram, routing flags and
// stamp split into hours, minutes, seconds and milliseconds by reciprocal
// multiplication; uses oetr_pkg and oetr_out_if
module oetr_split #(
  parameter int MSG_W = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   iss_v,
  input  oetr_pkg::meta_t        iss_meta,
  input  oetr_pkg::lim_t         lim,
  input  logic [oetr_pkg::LEVEL_W+oetr_pkg::TAG_W+oetr_pkg::TIME_W+MSG_W-1:0] rec_rdata,
  output logic                   adv,
  oetr_out_if.source             out_ch
);
  localparam int TW   = oetr_pkg::TIME_W;
  localparam int P1_W = TW + oetr_pkg::DIV1000_MUL_W;
  localparam int P2_W = oetr_pkg::Q1_W + oetr_pkg::DIV60_MUL_W;
  localparam int P3_W = oetr_pkg::Q2_W + oetr_pkg::DIV60_MUL_W;

  typedef struct packed {
    logic                         valid_res;
    logic                         last;
    logic [oetr_pkg::LEVEL_W-1:0] level;
    logic [oetr_pkg::TAG_W-1:0]   tag;
    logic [MSG_W-1:0]             msg;
    logic                         rem;
    logic                         ser;
    logic                         web;
  } carry_t;

  logic                          v0_r, v1_r, v2_r, v3_r, out_valid_r;
  oetr_pkg::meta_t               m0_r;
  carry_t                        c0, c1_r, c2_r, c3_r, oc_r;
  logic [TW-1:0]                 t0, t1_r;
  logic                          keep0;
  logic [P1_W-1:0]               p1_r;
  logic [P2_W-1:0]               p2_r;
  logic [P3_W-1:0]               p3_r;
  logic [oetr_pkg::Q1_W-1:0]     q1, q1_r;
  logic [oetr_pkg::Q2_W-1:0]     q2, q2_r;
  logic [oetr_pkg::HOURS_W-1:0]  hours;
  logic [TW-1:0]                 ms_full;
  logic [oetr_pkg::Q1_W-1:0]     sec_full;
  logic [oetr_pkg::Q2_W-1:0]     min_full;
  logic [oetr_pkg::MILLIS_W-1:0] ms2_r, ms3_r, ms_r;
  logic [oetr_pkg::SECONDS_W-1:0] sec3_r, sec_r;
  logic [oetr_pkg::MINUTES_W-1:0] min_r;
  logic [oetr_pkg::HOURS_W-1:0]  hours_r;

  logic [oetr_pkg::LEVEL_W-1:0]  rd_level;

  // the whole pipeline moves together when the output register can take
  assign adv = !out_valid_r || out_ch.ready;

  assign rd_level = rec_rdata[MSG_W+TW+oetr_pkg::TAG_W +: oetr_pkg::LEVEL_W];

  always_comb begin
    c0.valid_res = 1'b1;
    c0.last      = m0_r.last;
    c0.level     = rd_level;
    c0.tag       = rec_rdata[MSG_W+TW +: oetr_pkg::TAG_W];
    c0.msg       = rec_rdata[MSG_W-1:0];
    t0           = rec_rdata[MSG_W +: TW];
    keep0        = 1'b1;
    if (m0_r.invalid) begin
      c0      = '0;
      c0.last = 1'b1;
      t0      = '0;
    end else if (m0_r.hist) begin
      c0.rem = 1'b0;
      c0.ser = 1'b0;
      c0.web = 1'b1;
      keep0  = (rd_level <= lim.web);
    end else begin
      c0.rem = (rd_level <= lim.remote) && m0_r.net;
      c0.ser = (rd_level <= lim.serial);
      c0.web = (rd_level <= lim.web);
    end
  end

  assign q1       = p1_r[oetr_pkg::DIV1000_SH +: oetr_pkg::Q1_W];
  assign ms_full  = t1_r - (TW'(q1) * TW'(oetr_pkg::MS_PER_S));
  assign q2       = p2_r[oetr_pkg::DIV60_SH +: oetr_pkg::Q2_W];
  assign sec_full = q1_r - (oetr_pkg::Q1_W'(q2) * oetr_pkg::Q1_W'(oetr_pkg::S_PER_MIN));
  assign hours    = p3_r[oetr_pkg::DIV60_SH +: oetr_pkg::HOURS_W];
  assign min_full = q2_r - (oetr_pkg::Q2_W'(hours) * oetr_pkg::Q2_W'(oetr_pkg::MIN_PER_H));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v0_r        <= iss_v;
      v1_r        <= v0_r && keep0;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m0_r    <= iss_meta;
      c1_r    <= c0;
      t1_r    <= t0;
      p1_r    <= P1_W'(t0) * P1_W'(oetr_pkg::DIV1000_MUL);
      c2_r    <= c1_r;
      q1_r    <= q1;
      ms2_r   <= ms_full[oetr_pkg::MILLIS_W-1:0];
      p2_r    <= P2_W'(q1) * P2_W'(oetr_pkg::DIV60_MUL);
      c3_r    <= c2_r;
      q2_r    <= q2;
      ms3_r   <= ms2_r;
      sec3_r  <= sec_full[oetr_pkg::SECONDS_W-1:0];
      p3_r    <= P3_W'(q2) * P3_W'(oetr_pkg::DIV60_MUL);
      oc_r    <= c3_r;
      hours_r <= hours;
      min_r   <= min_full[oetr_pkg::MINUTES_W-1:0];
      sec_r   <= sec3_r;
      ms_r    <= ms3_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.valid_res     = oc_r.valid_res;
  assign out_ch.last          = oc_r.last;
  assign out_ch.rec_level     = oc_r.level;
  assign out_ch.rec_tag       = oc_r.tag;
  assign out_ch.rec_message   = oc_r.msg;
  assign out_ch.to_remote     = oc_r.rem;
  assign out_ch.to_serial     = oc_r.ser;
  assign out_ch.to_web        = oc_r.web;
  assign out_ch.stamp_hours   = hours_r;
  assign out_ch.stamp_minutes = min_r;
  assign out_ch.stamp_seconds = sec_r;
  assign out_ch.stamp_millis  = ms_r;

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !oc_r.valid_res) |-> (oc_r.last && !oc_r.web && hours_r == '0))
    else $error("empty result without last flag or with data");
endmodule

@@ design/overwriting_event_trace_ring_top.sv @@
// overwriting_event_trace_ring_top: trace ring of event records that overwrites
// the oldest when full; uses oetr_pkg, the channel interfaces, oetr_ram,
// oetr_ctrl and oetr_split
//
//  channel | dir | handshake     | payload
//  in_ch   | in  | valid / ready | opcode, level, tag, time_ms, message_ref, network_up
//  out_ch  | out | valid / ready | valid_res, last, record fields, stamp split, flags
//  cfg_ch  | in  | valid / ready | index, data (level limits, ready always high)
//
// push is written as it is taken; a pop result passes the ram read and split registers
// history: scans the filled slots of the level ram, then does one record ram read
// per cycle while not stalled, up to the last passing slot; no new command meanwhile
// unstalled, the record ram read port and stamp split pipeline carry one record a cycle
// reset clears pointers, counts and limits; ring contents are left as they are
// out_ready low with a result waiting freezes the whole result pipeline and drops in_ready
module overwriting_event_trace_ring_top #(
  parameter int RING_DEPTH       = 64,
  parameter int MESSAGE_REF_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  oetr_in_if.sink    in_ch,
  oetr_out_if.source out_ch,
  oetr_cfg_if.sink   cfg_ch
);
  localparam int AW    = $clog2(RING_DEPTH);
  localparam int REC_W = oetr_pkg::LEVEL_W + oetr_pkg::TAG_W + oetr_pkg::TIME_W
                         + MESSAGE_REF_BITS;

  logic                         adv;
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic [REC_W-1:0]             wr_data;
  logic                         rec_re;
  logic [AW-1:0]                rec_raddr;
  logic [REC_W-1:0]             rec_rdata;
  logic                         lvl_re;
  logic [AW-1:0]                lvl_raddr;
  logic [oetr_pkg::LEVEL_W-1:0] lvl_wdata;
  logic [oetr_pkg::LEVEL_W-1:0] lvl_rdata;
  logic                         iss_v;
  oetr_pkg::meta_t              iss_meta;
  oetr_pkg::lim_t               lim;

  // the level ram mirrors the level bits so the scan leaves the record port alone
  assign lvl_wdata = wr_data[REC_W-1 -: oetr_pkg::LEVEL_W];

  oetr_ctrl #(
    .RING_DEPTH (RING_DEPTH),
    .MSG_W      (MESSAGE_REF_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .adv       (adv),
    .lvl_rdata (lvl_rdata),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rec_re    (rec_re),
    .rec_raddr (rec_raddr),
    .lvl_re    (lvl_re),
    .lvl_raddr (lvl_raddr),
    .iss_v     (iss_v),
    .iss_meta  (iss_meta),
    .lim       (lim)
  );

  oetr_ram #(
    .WIDTH (REC_W),
    .DEPTH (RING_DEPTH)
  ) u_rec_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rec_re),
    .raddr (rec_raddr),
    .rdata (rec_rdata)
  );

  oetr_ram #(
    .WIDTH (oetr_pkg::LEVEL_W),
    .DEPTH (RING_DEPTH)
  ) u_lvl_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (lvl_wdata),
    .re    (lvl_re),
    .raddr (lvl_raddr),
    .rdata (lvl_rdata)
  );

  oetr_split #(
    .MSG_W (MESSAGE_REF_BITS)
  ) u_split (
    .clk       (clk),
    .rst_n     (rst_n),
    .iss_v     (iss_v),
    .iss_meta  (iss_meta),
    .lim       (lim),
    .rec_rdata (rec_rdata),
    .adv       (adv),
    .out_ch    (out_ch)
  );
endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: self-checking bench for overwriting_event_trace_ring_top, with push, pop and
// history transactions, a ring predictor and an in-order record check
// depends on oetr_pkg, oetr_in_if, oetr_out_if, oetr_cfg_if and the ring top level
module tb_top;

  localparam int DEPTH = 64;
  localparam int MSG_W = 16;
  localparam logic [oetr_pkg::OPCODE_W-1:0]  OP_NONE    = 2'd3;
  localparam logic [oetr_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;
  // a history scan holds no transaction while it walks the level ram
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 12;

  typedef struct packed {
    logic [oetr_pkg::OPCODE_W-1:0] opcode;
    logic [oetr_pkg::LEVEL_W-1:0]  level;
    logic [oetr_pkg::TAG_W-1:0]    tag;
    logic [oetr_pkg::TIME_W-1:0]   time_ms;
    logic [MSG_W-1:0]              message_ref;
    logic                          network_up;
  } trace_cmd_t;

  typedef struct packed {
    logic                           valid_res;
    logic                           last;
    logic [oetr_pkg::LEVEL_W-1:0]   level;
    logic [oetr_pkg::TAG_W-1:0]     tag;
    logic [oetr_pkg::HOURS_W-1:0]   hours;
    logic [oetr_pkg::MINUTES_W-1:0] minutes;
    logic [oetr_pkg::SECONDS_W-1:0] seconds;
    logic [oetr_pkg::MILLIS_W-1:0]  millis;
    logic [MSG_W-1:0]               message;
    logic                           to_remote;
    logic                           to_serial;
    logic                           to_web;
  } trace_record_t;

  logic clk;
  logic rst_n;

  oetr_in_if #(.MSG_W(MSG_W))  in_ch ();
  oetr_out_if #(.MSG_W(MSG_W)) out_ch ();
  oetr_cfg_if                  cfg_ch ();

  overwriting_event_trace_ring_top #(
    .RING_DEPTH(DEPTH),
    .MESSAGE_REF_BITS(MSG_W)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // shadow copy of the ring
  logic [oetr_pkg::LEVEL_W-1:0] ring_level [DEPTH];
  logic [oetr_pkg::TAG_W-1:0]   ring_tag [DEPTH];
  logic [oetr_pkg::TIME_W-1:0]  ring_time [DEPTH];
  logic [MSG_W-1:0]             ring_message [DEPTH];
  int   wr_ptr;
  int   rd_ptr;
  int   unsent;
  int   filled;
  oetr_pkg::lim_t limits;

  trace_record_t expected_records [$];
  int fail_count;
  int src_idle_pct;
  int sink_idle_pct;
  int quiet_cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  function automatic trace_record_t ring_record(input int slot, input logic is_last,
                                                input logic rem, input logic ser,
                                                input logic web);
    trace_record_t rec;
    logic [oetr_pkg::TIME_W-1:0] t;
    t = ring_time[slot];
    rec.valid_res = 1'b1;
    rec.last      = is_last;
    rec.level     = ring_level[slot];
    rec.tag       = ring_tag[slot];
    rec.hours     = oetr_pkg::HOURS_W'(t / 32'd3600000);
    rec.minutes   = oetr_pkg::MINUTES_W'((t / 32'd60000) % 32'd60);
    rec.seconds   = oetr_pkg::SECONDS_W'((t / 32'd1000) % 32'd60);
    rec.millis    = oetr_pkg::MILLIS_W'(t % 32'd1000);
    rec.message   = ring_message[slot];
    rec.to_remote = rem;
    rec.to_serial = ser;
    rec.to_web    = web;
    return rec;
  endfunction

  task automatic predict_trace(input trace_cmd_t c);
    trace_record_t rec;
    int slot;
    int passed;
    rec = '0;
    rec.last = 1'b1;
    case (c.opcode)
      oetr_pkg::OP_PUSH: begin
        ring_level[wr_ptr]   = c.level;
        ring_tag[wr_ptr]     = c.tag;
        ring_time[wr_ptr]    = c.time_ms;
        ring_message[wr_ptr] = c.message_ref;
        wr_ptr = (wr_ptr + 1) % DEPTH;
        unsent++;
        // full ring: the oldest record is lost and the read side follows
        if (unsent > DEPTH) begin
          rd_ptr = wr_ptr;
          unsent = DEPTH;
        end
        if (filled < DEPTH) filled++;
      end
      oetr_pkg::OP_POP: begin
        if (unsent == 0) begin
          expected_records.push_back(rec);
        end else begin
          expected_records.push_back(ring_record(rd_ptr, 1'b1,
            (ring_level[rd_ptr] <= limits.remote) && c.network_up,
            ring_level[rd_ptr] <= limits.serial,
            ring_level[rd_ptr] <= limits.web));
          rd_ptr = (rd_ptr + 1) % DEPTH;
          unsent--;
        end
      end
      oetr_pkg::OP_HIST: begin
        slot = (filled < DEPTH) ? 0 : wr_ptr;
        passed = 0;
        for (int i = 0; i < filled; i++) begin
          if (ring_level[slot] <= limits.web) begin
            expected_records.push_back(ring_record(slot, 1'b0, 1'b0, 1'b0, 1'b1));
            passed++;
          end
          slot = (slot + 1) % DEPTH;
        end
        if (passed == 0) expected_records.push_back(rec);
        else expected_records[$].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  // called just after a rising edge; returns at the edge that takes the transaction
  task automatic send_cmd(input logic [oetr_pkg::OPCODE_W-1:0] op,
                          input logic [oetr_pkg::LEVEL_W-1:0] lvl,
                          input logic [oetr_pkg::TAG_W-1:0] tg,
                          input logic [oetr_pkg::TIME_W-1:0] t,
                          input logic [MSG_W-1:0] msg, input logic net);
    trace_cmd_t c;
    c.opcode      = op;
    c.level       = lvl;
    c.tag         = tg;
    c.time_ms     = t;
    c.message_ref = msg;
    c.network_up  = net;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= c.opcode;
    in_ch.level       <= c.level;
    in_ch.tag         <= c.tag;
    in_ch.time_ms     <= c.time_ms;
    in_ch.message_ref <= c.message_ref;
    in_ch.network_up  <= c.network_up;
    do @(posedge clk); while (!in_ch.ready);
    predict_trace(c);
  endtask

  // pushes leave no result behind, so let the write path settle after the queue drains
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [oetr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [oetr_pkg::CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      oetr_pkg::CFG_REMOTE_LIMIT: limits.remote = val;
      oetr_pkg::CFG_SERIAL_LIMIT: limits.serial = val;
      oetr_pkg::CFG_WEB_LIMIT:    limits.web    = val;
      default: ;
    endcase
  endtask

  task automatic write_limits(input logic [oetr_pkg::LEVEL_W-1:0] rem,
                              input logic [oetr_pkg::LEVEL_W-1:0] ser,
                              input logic [oetr_pkg::LEVEL_W-1:0] web);
    wait_idle();
    cfg_write(oetr_pkg::CFG_REMOTE_LIMIT, rem);
    cfg_write(oetr_pkg::CFG_SERIAL_LIMIT, ser);
    cfg_write(oetr_pkg::CFG_WEB_LIMIT, web);
    // unused index last, so a wrongly taken write would show in the web limit
    cfg_write(CFG_NO_REG, ~web);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [oetr_pkg::TIME_W-1:0] rand_stamp();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(999999);
      2: return $urandom_range(1193) * 3600000 + $urandom_range(2000) - 1000;
      default: return 32'hFFFF_FFFF - $urandom_range(5000000);
    endcase
  endfunction

  function automatic logic [oetr_pkg::LEVEL_W-1:0] rand_level();
    if ($urandom_range(9) == 0) return 2'd3;
    return oetr_pkg::LEVEL_W'($urandom_range(2));
  endfunction

  task automatic test_empty_ring();
    send_cmd(oetr_pkg::OP_POP, 2'd0, 3'd0, 32'd0, 16'd0, 1'b1);
    send_cmd(oetr_pkg::OP_HIST, 2'd0, 3'd0, 32'd0, 16'd0, 1'b0);
    send_cmd(OP_NONE, 2'd3, 3'd7, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
  endtask

  task automatic test_field_extremes();
    write_limits(2'd2, 2'd1, 2'd0);
    send_cmd(oetr_pkg::OP_PUSH, 2'd0, 3'd0, 32'd0, 16'h0000, 1'b0);
    send_cmd(oetr_pkg::OP_PUSH, 2'd1, 3'd7, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    send_cmd(oetr_pkg::OP_PUSH, 2'd2, 3'd5, 32'd3599999, 16'h8000, 1'b0);
    send_cmd(oetr_pkg::OP_PUSH, 2'd3, 3'd2, 32'd3600000, 16'h0001, 1'b1);
    send_cmd(oetr_pkg::OP_PUSH, 2'd0, 3'd3, 32'd59999, 16'h5A5A, 1'b0);
    send_cmd(oetr_pkg::OP_HIST, 2'd0, 3'd0, 32'd0, 16'd0, 1'b0);
    send_cmd(oetr_pkg::OP_POP, 2'd0, 3'd0, 32'd0, 16'd0, 1'b0);
    send_cmd(oetr_pkg::OP_POP, 2'd0, 3'd0, 32'd0, 16'd0, 1'b1);
    send_cmd(oetr_pkg::OP_POP, 2'd0, 3'd0, 32'd0, 16'd0, 1'b1);
    send_cmd(oetr_pkg::OP_POP, 2'd0, 3'd0, 32'd0, 16'd0, 1'b1);
    send_cmd(oetr_pkg::OP_POP, 2'd0, 3'd0, 32'd0, 16'd0, 1'b0);
    // nothing left unsent, but the history still holds all five
    send_cmd(oetr_pkg::OP_POP, 2'd0, 3'd0, 32'd0, 16'd0, 1'b1);
    send_cmd(oetr_pkg::OP_HIST, 2'd0, 3'd0, 32'd0, 16'd0, 1'b1);
  endtask

  task automatic test_limit_registers();
    write_limits(2'd3, 2'd0, 2'd2);
    send_cmd(oetr_pkg::OP_PUSH, 2'd3, 3'd6, 32'd86399999, 16'h1234, 1'b0);
    send_cmd(oetr_pkg::OP_HIST, 2'd0, 3'd0, 32'd0, 16'd0, 1'b0);
    send_cmd(oetr_pkg::OP_POP, 2'd0, 3'd0, 32'd0, 16'd0, 1'b1);
    send_cmd(OP_NONE, 2'd1, 3'd1, 32'd1, 16'd1, 1'b0);
    send_cmd(oetr_pkg::OP_POP, 2'd0, 3'd0, 32'd0, 16'd0, 1'b1);
  endtask

  // push_pct above the pop share drives the ring into overwrite, below it drains it
  task automatic test_random_traffic(input int n_items, input int push_pct);
    int pick;
    logic [oetr_pkg::OPCODE_W-1:0] op;
    repeat (n_items) begin
      pick = $urandom_range(99);
      if (pick < 3) op = OP_NONE;
      else if (pick < 10) op = oetr_pkg::OP_HIST;
      else if (pick < 10 + push_pct) op = oetr_pkg::OP_PUSH;
      else op = oetr_pkg::OP_POP;
      send_cmd(op, rand_level(), oetr_pkg::TAG_W'($urandom_range(7)), rand_stamp(),
               MSG_W'($urandom_range(16'hFFFF)), 1'($urandom_range(1)));
    end
  endtask

  always @(posedge clk) begin
    trace_record_t got;
    trace_record_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.valid_res = out_ch.valid_res;
      got.last      = out_ch.last;
      got.level     = out_ch.rec_level;
      got.tag       = out_ch.rec_tag;
      got.hours     = out_ch.stamp_hours;
      got.minutes   = out_ch.stamp_minutes;
      got.seconds   = out_ch.stamp_seconds;
      got.millis    = out_ch.stamp_millis;
      got.message   = out_ch.rec_message;
      got.to_remote = out_ch.to_remote;
      got.to_serial = out_ch.to_serial;
      got.to_web    = out_ch.to_web;
      if (expected_records.size() == 0) begin
        report_mismatch("record with none pending, valid_res", 32'(got.valid_res), 32'd0);
      end else begin
        want = expected_records.pop_front();
        if (got.valid_res !== want.valid_res)
          report_mismatch("valid_res", 32'(got.valid_res), 32'(want.valid_res));
        if (got.last !== want.last)
          report_mismatch("last", 32'(got.last), 32'(want.last));
        if (got.level !== want.level)
          report_mismatch("rec_level", 32'(got.level), 32'(want.level));
        if (got.tag !== want.tag)
          report_mismatch("rec_tag", 32'(got.tag), 32'(want.tag));
        if (got.hours !== want.hours)
          report_mismatch("stamp_hours", 32'(got.hours), 32'(want.hours));
        if (got.minutes !== want.minutes)
          report_mismatch("stamp_minutes", 32'(got.minutes), 32'(want.minutes));
        if (got.seconds !== want.seconds)
          report_mismatch("stamp_seconds", 32'(got.seconds), 32'(want.seconds));
        if (got.millis !== want.millis)
          report_mismatch("stamp_millis", 32'(got.millis), 32'(want.millis));
        if (got.message !== want.message)
          report_mismatch("rec_message", 32'(got.message), 32'(want.message));
        if (got.to_remote !== want.to_remote)
          report_mismatch("to_remote", 32'(got.to_remote), 32'(want.to_remote));
        if (got.to_serial !== want.to_serial)
          report_mismatch("to_serial", 32'(got.to_serial), 32'(want.to_serial));
        if (got.to_web !== want.to_web)
          report_mismatch("to_web", 32'(got.to_web), 32'(want.to_web));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.opcode      = oetr_pkg::OP_PUSH;
    in_ch.level       = '0;
    in_ch.tag         = '0;
    in_ch.time_ms     = '0;
    in_ch.message_ref = '0;
    in_ch.network_up  = 1'b0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = oetr_pkg::CFG_REMOTE_LIMIT;
    cfg_ch.data       = '0;
    wr_ptr            = 0;
    rd_ptr            = 0;
    unsent            = 0;
    filled            = 0;
    limits            = '0;
    fail_count        = 0;
    quiet_cycles      = 0;
    src_idle_pct      = 9;
    sink_idle_pct     = 60;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_ring();
    test_field_extremes();
    test_limit_registers();

    write_limits(2'd2, 2'd1, 2'd2);
    test_random_traffic(150, 70);

    write_limits(2'd0, 2'd2, 2'd1);
    src_idle_pct  = 60;
    sink_idle_pct = 9;
    test_random_traffic(150, 30);

    write_limits(2'd1, 2'd3, 2'd3);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_traffic(150, 50);

    wait_idle();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
